/* hdl/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// plain check including reset cycles
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hdl/owm_pkg.sv */
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants for the 1-Wire master.
// ----------------------------------------------------------------------------
package owm_pkg;
  localparam int NUM_REGS = 7;
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_RESET  = 3'd1;
  localparam logic [2:0] CMD_WRITE  = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_SEARCH = 3'd4;
  localparam logic [2:0] REG_RST_LOW  = 3'd0;
  localparam logic [2:0] REG_PRES     = 3'd1;
  localparam logic [2:0] REG_RST_TAIL = 3'd2;
  localparam logic [2:0] REG_SLOT     = 3'd3;
  localparam logic [2:0] REG_WHOLD    = 3'd4;
  localparam logic [2:0] REG_RSAMP    = 3'd5;
  localparam logic [2:0] REG_RTAIL    = 3'd6;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PRES = 2'd1;
  localparam logic [1:0] ST_PAIR11  = 2'd2;
  localparam logic [7:0] SEARCH_ROM = 8'hF0;
  typedef logic [9:0] ticks_t;
  typedef struct packed {
    ticks_t rst_low;
    ticks_t pres;
    ticks_t rst_tail;
    ticks_t slot;
    ticks_t whold;
    ticks_t rsamp;
    ticks_t rtail;
  } timing_t;
endpackage

/* hdl/onewire_master_with_rom_search.sv */
// ----------------------------------------------------------------------------
// onewire_master_with_rom_search
// 1-Wire bus master with reset, byte write/read and ROM search pass.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words (s_axis) are either commands (reset, write byte, read byte,
//    search pass) or tick words (cmd 0) that carry the sampled bus level and
//    advance the bus sequencer by one microsecond step.
//  - Every input word yields exactly one output word (m_axis) carrying the
//    drive_low level, busy/done flags, status and the last read/search data.
//  - Accepted words go straight to the output register. Throughput: one word
//    per cycle unless stalled; the sequencer step is a single registered pass.
//  - A stalled receiver holds the output word and stalls the input; a new
//    word is taken only while the output register is empty or being drained, i.e.
//    s_tready = !m_tvalid || m_tready.
//  - Commands arriving while busy are dropped (their output is still given).
//  - Reset: sequencer idle, all data cleared, timing registers at defaults.
//  - Timing registers live on the APB port at 4*index; write only when idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module onewire_master_with_rom_search
  import owm_pkg::*;
#(
  parameter int ROM_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: [2:0] cmd, [3] line_in, [11:4] tx_byte, [18:12] start_diff
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
  // [5] presence, [13:6] rx_byte, [20:14] last_disc, [84:21] rom_id
  output logic [87:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_GAP,
    PH_LOW, PH_WHOLD, PH_RWAIT, PH_RTAIL
  } phase_t;
  typedef enum logic [2:0] {
    OP_NONE, OP_RESET, OP_WRITE, OP_READ, OP_SCMD, OP_SR1, OP_SR2, OP_SW
  } op_t;

  timing_t timing;
  owm_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .timing
  );

  phase_t phase, phase_next;
  op_t    op_kind, op_kind_next;
  logic [9:0]  tick_count, tick_count_next;
  logic [6:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [63:0] found_id, found_id_next;
  logic [6:0]  pass_diff, pass_diff_next, new_diff, new_diff_next;
  logic first_bit, first_bit_next, chosen_bit, chosen_bit_next;
  logic presence_seen, presence_seen_next, done_flag;
  logic [1:0] last_status, last_status_next;
  logic [7:0] rx_hold, rx_hold_next;

  logic [2:0] cmd;
  logic line_in;
  logic [7:0] tx_byte;
  logic [6:0] start_diff;
  assign cmd = s_tdata[2:0];
  assign line_in = s_tdata[3];
  assign tx_byte = s_tdata[11:4];
  assign start_diff = s_tdata[18:12];

  logic take;
  assign s_tready = !m_tvalid || m_tready;
  assign take = s_tvalid && s_tready;

  // timing limit of the current phase and the counter step
  ticks_t limit;
  logic [9:0] cnt_inc;
  logic expired;
  always_comb begin
    case (phase)
      PH_RST_LOW:  limit = timing.rst_low;
      PH_RST_WAIT: limit = timing.pres;
      PH_RST_TAIL: limit = timing.rst_tail;
      PH_LOW:      limit = timing.slot;
      PH_WHOLD:    limit = timing.whold;
      PH_RWAIT:    limit = timing.rsamp;
      default:     limit = timing.rtail;
    endcase
    cnt_inc = tick_count + 10'd1;
    expired = cnt_inc >= limit;
  end

  logic [6:0] pos;
  logic prev_bit;
  logic [5:0] bidx6;
  assign bidx6 = bit_index[5:0];
  assign pos = 7'(ROM_BITS) - bit_index;
  assign prev_bit = found_id[bidx6];

  always_comb begin
    phase_next = phase; op_kind_next = op_kind; tick_count_next = tick_count;
    bit_index_next = bit_index; shift_byte_next = shift_byte;
    found_id_next = found_id; pass_diff_next = pass_diff;
    new_diff_next = new_diff; first_bit_next = first_bit;
    chosen_bit_next = chosen_bit; presence_seen_next = presence_seen;
    last_status_next = last_status; rx_hold_next = rx_hold; done_flag = 1'b0;
    if (cmd != CMD_TICK) begin
      if (phase == PH_IDLE && cmd <= CMD_SEARCH) begin
        tick_count_next = '0;
        bit_index_next = '0;
        case (cmd)
          CMD_RESET: begin
            op_kind_next = OP_RESET; phase_next = PH_RST_LOW;
          end
          CMD_WRITE: begin
            op_kind_next = OP_WRITE; shift_byte_next = tx_byte;
            phase_next = PH_LOW;
          end
          CMD_READ: begin
            op_kind_next = OP_READ; shift_byte_next = '0; phase_next = PH_LOW;
          end
          default: begin
            op_kind_next = OP_SCMD; pass_diff_next = start_diff;
            new_diff_next = '0; phase_next = PH_RST_LOW;
          end
        endcase
      end
    end else if (phase != PH_IDLE) begin
      if (phase == PH_GAP) begin
        tick_count_next = '0; phase_next = PH_LOW;
      end else begin
        tick_count_next = expired ? 10'd0 : cnt_inc;
        if (expired) begin
          unique case (phase)
            PH_RST_LOW: phase_next = PH_RST_WAIT;
            PH_RST_WAIT: begin
              presence_seen_next = !line_in; phase_next = PH_RST_TAIL;
            end
            PH_RST_TAIL: begin
              if (op_kind != OP_SCMD || !presence_seen) begin
                phase_next = PH_IDLE; op_kind_next = OP_NONE; done_flag = 1'b1;
                last_status_next = presence_seen ? ST_OK : ST_NO_PRES;
              end else begin
                shift_byte_next = SEARCH_ROM; bit_index_next = '0;
                phase_next = PH_GAP;
              end
            end
            PH_LOW: phase_next = (op_kind == OP_WRITE || op_kind == OP_SCMD ||
                                  op_kind == OP_SW) ? PH_WHOLD : PH_RWAIT;
            PH_RWAIT: begin
              chosen_bit_next = line_in; phase_next = PH_RTAIL;
            end
            PH_WHOLD, PH_RTAIL: begin
              // slot end
              phase_next = PH_GAP;
              case (op_kind)
                OP_WRITE, OP_SCMD: begin
                  shift_byte_next = shift_byte >> 1;
                  bit_index_next = bit_index + 7'd1;
                  if (bit_index_next >= 7'd8) begin
                    if (op_kind == OP_WRITE) begin
                      phase_next = PH_IDLE; op_kind_next = OP_NONE;
                      last_status_next = ST_OK; done_flag = 1'b1;
                    end else begin
                      op_kind_next = OP_SR1; bit_index_next = '0;
                    end
                  end
                end
                OP_READ: begin
                  shift_byte_next = {chosen_bit, shift_byte[7:1]};
                  bit_index_next = bit_index + 7'd1;
                  if (bit_index_next >= 7'd8) begin
                    rx_hold_next = shift_byte_next;
                    phase_next = PH_IDLE; op_kind_next = OP_NONE;
                    last_status_next = ST_OK; done_flag = 1'b1;
                  end
                end
                OP_SR1: begin
                  first_bit_next = chosen_bit; op_kind_next = OP_SR2;
                end
                OP_SR2: begin
                  if (first_bit && chosen_bit) begin
                    phase_next = PH_IDLE; op_kind_next = OP_NONE;
                    last_status_next = ST_PAIR11; done_flag = 1'b1;
                  end else begin
                    chosen_bit_next = first_bit;
                    if (!first_bit && !chosen_bit) begin
                      chosen_bit_next = 1'b0;
                      if (pass_diff > pos || (prev_bit && pass_diff != pos)) begin
                        chosen_bit_next = 1'b1; new_diff_next = pos;
                      end
                    end
                    op_kind_next = OP_SW;
                  end
                end
                OP_SW: begin
                  found_id_next[bidx6] = chosen_bit;
                  bit_index_next = bit_index + 7'd1;
                  if (bit_index_next >= 7'(ROM_BITS)) begin
                    phase_next = PH_IDLE; op_kind_next = OP_NONE;
                    last_status_next = ST_OK; done_flag = 1'b1;
                  end else begin
                    op_kind_next = OP_SR1;
                  end
                end
                default: begin
                  phase_next = PH_IDLE; op_kind_next = OP_NONE;
                  last_status_next = ST_OK; done_flag = 1'b1;
                end
              endcase
            end
            default: ;
          endcase
        end
      end
    end
  end

  logic drive_next;
  always_comb begin
    if (phase_next == PH_RST_LOW || phase_next == PH_LOW) drive_next = 1'b1;
    else if (phase_next == PH_WHOLD)
      drive_next = (op_kind_next == OP_SW) ? !chosen_bit_next : !shift_byte_next[0];
    else drive_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; op_kind <= OP_NONE; tick_count <= '0; bit_index <= '0;
      shift_byte <= '0; found_id <= '0; pass_diff <= '0; new_diff <= '0;
      first_bit <= 1'b0; chosen_bit <= 1'b0; presence_seen <= 1'b0;
      last_status <= '0; rx_hold <= '0; m_tvalid <= 1'b0; m_tdata <= '0;
    end else begin
      if (take) begin
        phase <= phase_next; op_kind <= op_kind_next;
        tick_count <= tick_count_next; bit_index <= bit_index_next;
        shift_byte <= shift_byte_next; found_id <= found_id_next;
        pass_diff <= pass_diff_next; new_diff <= new_diff_next;
        first_bit <= first_bit_next; chosen_bit <= chosen_bit_next;
        presence_seen <= presence_seen_next; last_status <= last_status_next;
        rx_hold <= rx_hold_next;
        m_tvalid <= 1'b1;
        m_tdata <= {3'b000, found_id_next, new_diff_next, rx_hold_next,
                    presence_seen_next, last_status_next, done_flag,
                    phase_next != PH_IDLE, drive_next};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid,
              "output word dropped under stall")
  `ASSERT_CLK(a_done_idle, clk, rst, m_tvalid && m_tdata[2] |-> !m_tdata[1],
              "done while still busy")
  `ASSERT_CLK(a_idle_release, clk, rst, phase == PH_IDLE |-> op_kind == OP_NONE,
              "idle with an operation pending")
endmodule

/* hdl/owm_regs.sv */
// ----------------------------------------------------------------------------
// owm_regs
// APB timing register file.
// ----------------------------------------------------------------------------
module owm_regs
  import owm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output timing_t     timing
);
  logic we;
  assign pready = 1'b1;
  assign we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing <= '{10'd480, 10'd60, 10'd420, 10'd1, 10'd60, 10'd14, 10'd45};
    end else if (we && paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        REG_RST_LOW:  timing.rst_low  <= pwdata[9:0];
        REG_PRES:     timing.pres     <= pwdata[9:0];
        REG_RST_TAIL: timing.rst_tail <= pwdata[9:0];
        REG_SLOT:     timing.slot     <= pwdata[9:0];
        REG_WHOLD:    timing.whold    <= pwdata[9:0];
        REG_RSAMP:    timing.rsamp    <= pwdata[9:0];
        REG_RTAIL:    timing.rtail    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_RST_LOW:  prdata[9:0] = timing.rst_low;
      REG_PRES:     prdata[9:0] = timing.pres;
      REG_RST_TAIL: prdata[9:0] = timing.rst_tail;
      REG_SLOT:     prdata[9:0] = timing.slot;
      REG_WHOLD:    prdata[9:0] = timing.whold;
      REG_RSAMP:    prdata[9:0] = timing.rsamp;
      REG_RTAIL:    prdata[9:0] = timing.rtail;
      default:      prdata = '0;
    endcase
  end
endmodule
